FILE: src/modular_exponentiation_unit_defines.svh
// Assertion shorthands for the modular exponentiation unit.
// Both expect i_clk and i_rst_n to be visible where they are used.
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("modular exponentiation check failed");

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("modular exponentiation check failed");

`endif

FILE: src/mexp_pkg.sv
package mexp_pkg;

    // Width of the arithmetic datapath.
    localparam int WIDTH   = 32;
    // Width of every field on the ports.
    localparam int FIELD_W = 32;
    // Width of the bit counter of the modular multiplier.
    localparam int CNT_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef logic [WIDTH-1:0] t_val;

    typedef struct packed {
        logic start;
        t_val x;
        t_val y;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
        t_val result;
    } t_mul_rsp;

endpackage

FILE: src/modular_exponentiation_unit.sv
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// One shared shift-and-add modular multiplier does all the arithmetic, one
// bit per cycle. Each multiplication passes through the request register,
// the multiplier's shifting steps over every bit and the done strobe on
// which the product is taken back. After a beat is accepted, the base is
// reduced by one multiplication, followed by the first decision step. Every
// exponent bit below the highest set one then costs a decision step, a
// multiply when the bit is set, and a square. The highest set bit costs a
// decision and a multiply only. The S_DONE state then loads the output
// register. An exponent of 0 goes from the first decision step straight to
// the output register. A modulus of 0 or 1 skips the multiplier and goes
// straight to the output register (the answer is 0). The input is not
// ready while an item is being worked on. A finished result waits in the
// output register while the next beat is accepted. If that register is
// still full when the following result is ready, the block stalls until
// the receiver takes the waiting beat.
`include "modular_exponentiation_unit_defines.svh"

module modular_exponentiation_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [mexp_pkg::FIELD_W-1:0]   i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] base_value, [63:32] exponent
    input  logic [2*mexp_pkg::FIELD_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] power_mod
    output logic [mexp_pkg::FIELD_W-1:0]   m_axis_tdata
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    t_state   r_state;
    t_mul_req r_req;
    t_mul_rsp mul_rsp;
    t_val     r_modulus;
    t_val     r_acc;
    t_val     r_sq;
    t_val     r_exp;
    t_val     r_res;
    logic     r_out_valid;
    logic [FIELD_W-1:0] r_out_data;

    logic mod_trivial;

    assign mod_trivial = (r_modulus[WIDTH-1:1] == '0);

    mexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_modulus),
        .i_req     (r_req),
        .o_rsp     (mul_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req.start <= 1'b0;
            r_modulus   <= WIDTH'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (i_cfg_wr_en) begin
                r_modulus <= WIDTH'(i_cfg_wr_data);
            end
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_exp <= WIDTH'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
                        r_acc <= WIDTH'(1);
                        if (mod_trivial) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            // base mod n is the product 1 * base, the base
                            // only feeding the multiplier bits.
                            r_req.start <= 1'b1;
                            r_req.x     <= WIDTH'(1);
                            r_req.y     <= WIDTH'(s_axis_tdata[FIELD_W-1:0]);
                            r_state     <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE: begin
                    if (mul_rsp.done) begin
                        r_sq    <= mul_rsp.result;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_exp == '0) begin
                        r_res   <= r_acc;
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_req.start <= 1'b1;
                        r_req.x     <= r_acc;
                        r_req.y     <= r_sq;
                        r_state     <= S_MUL;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.x     <= r_sq;
                        r_req.y     <= r_sq;
                        r_state     <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (mul_rsp.done) begin
                        r_acc <= mul_rsp.result;
                        if (r_exp[WIDTH-1:1] == '0) begin
                            // Top bit handled: no further square is needed.
                            r_res   <= mul_rsp.result;
                            r_state <= S_DONE;
                        end else begin
                            r_req.start <= 1'b1;
                            r_req.x     <= r_sq;
                            r_req.y     <= r_sq;
                            r_state     <= S_SQR;
                        end
                    end
                end
                S_SQR: begin
                    if (mul_rsp.done) begin
                        r_sq    <= mul_rsp.result;
                        r_exp   <= {1'b0, r_exp[WIDTH-1:1]};
                        r_state <= S_STEP;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= FIELD_W'(r_res);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `MEXP_ASSERT_SAME(a_start_when_free, r_req.start, !mul_rsp.busy)
    `MEXP_ASSERT_SAME(a_done_when_waiting, mul_rsp.done,
        (r_state == S_REDUCE) || (r_state == S_MUL) || (r_state == S_SQR))
    `MEXP_ASSERT_NEXT(a_accept_moves_on, s_axis_tvalid && s_axis_tready,
        (r_state == S_REDUCE) || (r_state == S_DONE))
    `MEXP_ASSERT_SAME(a_busy_not_ready, mul_rsp.busy, !s_axis_tready)

endmodule

FILE: src/mexp_mulmod.sv
module mexp_mulmod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mexp_pkg::t_val     i_modulus,
    input  mexp_pkg::t_mul_req i_req,
    output mexp_pkg::t_mul_rsp o_rsp
);
    import mexp_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_val             r_acc;
    t_val             r_x;
    t_val             r_y;

    logic [WIDTH:0] dbl;
    t_val           dbl_red;
    logic [WIDTH:0] sum;
    t_val           sum_red;
    t_val           n_acc;

    // One step of interleaved reduction: double the accumulator, then add x
    // when the current multiplier bit is set, each followed by one
    // conditional subtraction of the modulus.
    always_comb begin
        dbl     = {1'b0, r_acc} + {1'b0, r_acc};
        dbl_red = (dbl >= {1'b0, i_modulus}) ? WIDTH'(dbl - {1'b0, i_modulus})
                                             : dbl[WIDTH-1:0];
        sum     = {1'b0, dbl_red} + {1'b0, r_x};
        sum_red = (sum >= {1'b0, i_modulus}) ? WIDTH'(sum - {1'b0, i_modulus})
                                             : sum[WIDTH-1:0];
        n_acc   = r_y[WIDTH-1] ? sum_red : dbl_red;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH - 1);
                r_acc  <= '0;
                r_x    <= i_req.x;
                r_y    <= i_req.y;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_y   <= {r_y[WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

FILE: tb/modular_exponentiation_unit_tb.sv
module modular_exponentiation_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = mexp_pkg::FIELD_W;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int HOLD_CYCLES = 3000;
    localparam bit [FW-1:0] ALL_ONES = '1;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [FW-1:0]     i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // [31:0] base_value, [63:32] exponent
    logic [2*FW-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // [31:0] power_mod
    logic [FW-1:0]     m_axis_tdata;

    bit [FW-1:0] expected_power_mod[$];
    bit [FW-1:0] modulus_setting = 1;
    bit [FW-1:0] wanted_power_mod;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          hold_left = 0;
    logic        hold_pulse = 1'b0;

    modular_exponentiation_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("modular_exponentiation_unit regression: fail");
            $finish;
        end
    end

    // Square-and-multiply from the low exponent bit up. Operands stay below
    // the modulus, so every product fits in 64 bits before it is reduced.
    function automatic bit [FW-1:0] predict_power_mod(bit [FW-1:0] base_v,
                                                      bit [FW-1:0] exp_v,
                                                      bit [FW-1:0] n);
        bit [63:0]   acc;
        bit [63:0]   sq;
        bit [63:0]   m;
        bit [FW-1:0] e;
        if (n <= 1)
            return '0;
        m = n;
        acc = 1;
        sq = base_v % m;
        e = exp_v;
        while (e != 0) begin
            if (e[0])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e = e >> 1;
        end
        return acc[FW-1:0];
    endfunction

    // Receiver: random stalls, plus a long hold-off when the test asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_pulse) begin
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_power_mod.size() == 0) begin
                $error("power_mod: no result expected, actual %h", m_axis_tdata);
                fail_count++;
            end else begin
                wanted_power_mod = expected_power_mod.pop_front();
                if (m_axis_tdata !== wanted_power_mod) begin
                    $error("power_mod: expected %h, actual %h",
                           wanted_power_mod, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_operands(bit [FW-1:0] base_v, bit [FW-1:0] exp_v);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {exp_v, base_v};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        expected_power_mod.push_back(predict_power_mod(base_v, exp_v, modulus_setting));
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 2500)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Stops offering beats and waits until every result has been taken.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_power_mod.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_modulus(bit [FW-1:0] n);
        settle_block();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= n;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        modulus_setting = n;
    endtask

    function automatic bit [FW-1:0] pick_modulus();
        bit [FW-1:0] n;
        case ($urandom_range(3))
            0: n = $urandom() | 32'h8000_0000;
            1: n = $urandom() >> $urandom_range(1, 30);
            2: n = $urandom_range(2, 1000);
            default: n = ($urandom_range(1) == 0) ? ALL_ONES : FW'($urandom());
        endcase
        return (n < 2) ? FW'(2) : n;
    endfunction

    // The modulus is still at its reset value of one: everything reduces to 0.
    task automatic test_modulus_one();
        send_operands(5, 0);
        send_operands(ALL_ONES, ALL_ONES);
        settle_block();
    endtask

    task automatic test_edge_cases();
        // A zero modulus behaves as a modulus of one.
        write_modulus(0);
        send_operands(7, 0);
        send_operands(0, 0);
        write_modulus(ALL_ONES);
        send_operands(0, 0);
        send_operands(0, 5);
        send_operands(ALL_ONES, 1);
        send_operands(ALL_ONES - 1, ALL_ONES);
        send_operands(2, 31);
        send_operands(2, 32);
        send_operands(3, ALL_ONES);
        send_operands(32'h1234_5678, 1);
        write_modulus(2);
        send_operands(1, 0);
        send_operands(3, ALL_ONES);
        send_operands(2, 1);
        // A prime modulus, so Fermat's little theorem gives a known answer.
        write_modulus(32'hFFFF_FFFB);
        send_operands(ALL_ONES, ALL_ONES);
        send_operands(5, 32'hFFFF_FFFA);
        send_operands(32'hFFFF_FFFB, 3);
        send_operands(32'hFFFF_FFFC, ALL_ONES);
        write_modulus(32'h8000_0000);
        send_operands(3, ALL_ONES);
        send_operands(2, 31);
        send_operands(2, 30);
        settle_block();
    endtask

    task automatic test_random_operands(int count);
        bit [FW-1:0] base_v;
        bit [FW-1:0] exp_v;
        for (int i = 0; i < count; i++) begin
            if (i % 31 == 0)
                write_modulus(pick_modulus());
            case ($urandom_range(7))
                0: base_v = 0;
                1: base_v = 1;
                2: base_v = modulus_setting - 1;
                3: base_v = ALL_ONES;
                default: base_v = $urandom();
            endcase
            case ($urandom_range(4))
                0, 1: exp_v = $urandom();
                2, 3: exp_v = $urandom() >> $urandom_range(0, 31);
                default: exp_v = $urandom_range(0, 3);
            endcase
            send_operands(base_v, exp_v);
        end
        settle_block();
    endtask

    // Short exponents keep items quick, so the held output fills the block
    // and the input has to stall until the receiver lets go.
    task automatic test_output_backpressure();
        write_modulus(pick_modulus());
        hold_pulse <= 1'b1;
        @(posedge i_clk);
        hold_pulse <= 1'b0;
        for (int i = 0; i < 6; i++)
            send_operands($urandom(), $urandom_range(0, 15));
        settle_block();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 38;
        sink_idle_pct = 80;
        test_modulus_one();
        test_edge_cases();
        test_random_operands(84);

        src_idle_pct = 80;
        sink_idle_pct = 38;
        test_random_operands(84);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_random_operands(84);
        test_output_backpressure();

        settle_block();
        repeat (20) @(posedge i_clk);
        if (expected_power_mod.size() != 0) begin
            $error("power_mod: %0d results never arrived", expected_power_mod.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("modular_exponentiation_unit regression: pass");
        else
            $display("modular_exponentiation_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/modular_exponentiation_unit.sv
tb/modular_exponentiation_unit_tb.sv
